### sv/bacs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob area and centroid sums: shared package
// Frame geometry, memory widths, register indexes and record types.
// ----------------------------------------------------------------------------
package bacs_pkg;

	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 256;
	localparam int MAX_BLOBS = 16;

	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int PIX_CAP = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W  = $clog2(PIX_CAP);
	localparam int POS_W   = ADDR_W + 1;
	localparam int BIDX_W  = $clog2(MAX_BLOBS);
	localparam int BCNT_W  = $clog2(MAX_BLOBS + 1);

	// Field widths of the channels and the configuration registers.
	localparam int PIXEL_W  = 8;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 17;
	localparam int SUM_W    = 23;
	localparam int TOTAL_W  = 5;
	localparam int CFG_W    = 9;

	// Configuration register indexes.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   xs;
		logic [SUM_W-1:0]   ys;
	} blob_rec_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pos_t;

endpackage

### sv/bacs_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob area and centroid sums: channel interfaces
// Pixel request channel and blob result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bacs_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [bacs_pkg::PIXEL_W-1:0]  pixel_value;
	logic                          frame_end;

	modport source (output valid, output pixel_value, output frame_end, input ready);
	modport sink (input valid, input pixel_value, input frame_end, output ready);
endinterface

interface bacs_blob_if;
	logic                          valid;
	logic                          ready;
	logic [bacs_pkg::INDEX_W-1:0]  blob_index;
	logic [bacs_pkg::COUNT_W-1:0]  pixel_count;
	logic [bacs_pkg::SUM_W-1:0]    x_sum;
	logic [bacs_pkg::SUM_W-1:0]    y_sum;
	logic [bacs_pkg::TOTAL_W-1:0]  blob_total;
	logic                          last_blob;

	modport source (output valid, output blob_index, output pixel_count, output x_sum,
		output y_sum, output blob_total, output last_blob, input ready);
	modport sink (input valid, input blob_index, input pixel_count, input x_sum,
		input y_sum, input blob_total, input last_blob, output ready);
endinterface

### sv/blob_area_centroid_sums_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob area and centroid sums
// 4-connected blob labeling with per-blob pixel count and coordinate sums.
// ----------------------------------------------------------------------------
// The block takes a thresholded frame, one pixel request per cycle while it
// is loading, in raster order (nonzero is foreground) into a one-bit frame
// memory. The request marked frame_end closes the frame; the block then
// stops taking pixels, scans the stored frame and flood-fills each
// foreground pixel it meets, using a pixel stack memory, for up to MAX_BLOBS
// blobs. One result per blob follows, with a total count and a last flag; an
// empty frame gives a single all-zero result with last_blob set. The scan
// reads each pixel position and then checks it. Each blob pixel is popped
// from the stack, then each of its in-range neighbours is read and checked.
// Each result is read from the blob table into the output register. No
// clearing pass is needed after reset. Configuration registers: image_width
// at byte 0 and image_height at byte 4, 9 bits each, reset 256; a value of 0
// acts as 1 and a value above the maximum acts as the maximum. Pixels past
// width times height are dropped, and pixels missing from a short frame are
// background.
// ----------------------------------------------------------------------------
module blob_area_centroid_sums_top (
	input  logic                   clk,
	input  logic                   arst_n,
	bacs_pixel_if.sink             pixels,
	bacs_blob_if.source            blobs,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int COL_W  = bacs_pkg::COL_W;
	localparam int ROW_W  = bacs_pkg::ROW_W;
	localparam int ADDR_W = bacs_pkg::ADDR_W;
	localparam int POS_W  = bacs_pkg::POS_W;
	localparam int CFG_W  = bacs_pkg::CFG_W;

	// Sequencer states.
	localparam logic [2:0] ST_LOAD     = 3'd0;
	localparam logic [2:0] ST_SCAN_RD  = 3'd1;
	localparam logic [2:0] ST_SCAN_CHK = 3'd2;
	localparam logic [2:0] ST_POP      = 3'd3;
	localparam logic [2:0] ST_POP_W    = 3'd4;
	localparam logic [2:0] ST_NB_RD    = 3'd5;
	localparam logic [2:0] ST_NB_CHK   = 3'd6;
	localparam logic [2:0] ST_OUT      = 3'd7;

	// Neighbour order matches the fill order: right, left, down, up.
	localparam logic [1:0] NB_RIGHT = 2'd0;
	localparam logic [1:0] NB_LEFT  = 2'd1;
	localparam logic [1:0] NB_DOWN  = 2'd2;
	localparam logic [1:0] NB_UP    = 2'd3;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(bacs_pkg::MAX_COLS);
			height_q <= CFG_W'(bacs_pkg::MAX_ROWS);
		end else if (cfg_wr) begin
			if (paddr[2] == bacs_pkg::REG_WIDTH) begin
				width_q <= pwdata[CFG_W-1:0];
			end else begin
				height_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == bacs_pkg::REG_WIDTH) begin
			prdata = 32'(width_q);
		end else begin
			prdata = 32'(height_q);
		end
	end

	// Effective frame size: zero acts as one, oversize is clamped.
	logic [COL_W:0] w_eff;
	logic [ROW_W:0] h_eff;
	logic [POS_W-1:0] frame_size;

	always_comb begin
		if (width_q == '0) begin
			w_eff = (COL_W+1)'(1);
		end else if (width_q > CFG_W'(bacs_pkg::MAX_COLS)) begin
			w_eff = (COL_W+1)'(bacs_pkg::MAX_COLS);
		end else begin
			w_eff = width_q[COL_W:0];
		end
		if (height_q == '0) begin
			h_eff = (ROW_W+1)'(1);
		end else if (height_q > CFG_W'(bacs_pkg::MAX_ROWS)) begin
			h_eff = (ROW_W+1)'(bacs_pkg::MAX_ROWS);
		end else begin
			h_eff = height_q[ROW_W:0];
		end
	end

	assign frame_size = POS_W'(w_eff * h_eff);

	// ------------------------------------------------------------------
	// Sequencer registers.
	// ------------------------------------------------------------------
	logic [2:0]               state_q;
	logic [POS_W-1:0]         load_pos_q;
	logic [POS_W-1:0]         scan_addr_q;
	logic [COL_W-1:0]         scan_col_q;
	logic [ROW_W-1:0]         scan_row_q;
	logic [POS_W-1:0]         sp_q;
	logic [bacs_pkg::BCNT_W-1:0] found_q;
	logic [bacs_pkg::BCNT_W-1:0] out_idx_q;
	logic [1:0]               nb_q;
	logic [COL_W-1:0]         cur_col_q;
	logic [ROW_W-1:0]         cur_row_q;
	logic [POS_W-1:0]         cur_addr_q;
	bacs_pkg::blob_rec_t      acc_q;
	logic                     out_valid_q;

	// ------------------------------------------------------------------
	// Memories: frame bitmap, fill stack and blob table.
	// ------------------------------------------------------------------
	logic                     bm_mem [bacs_pkg::PIX_CAP];
	logic                     bm_we;
	logic                     bm_re;
	logic [ADDR_W-1:0]        bm_waddr;
	logic                     bm_wdata;
	logic [ADDR_W-1:0]        bm_raddr;
	logic                     bm_rdata;

	bacs_pkg::pos_t           stk_mem [bacs_pkg::PIX_CAP];
	logic                     stk_we;
	logic                     stk_re;
	logic [ADDR_W-1:0]        stk_waddr;
	bacs_pkg::pos_t           stk_wdata;
	logic [ADDR_W-1:0]        stk_raddr;
	bacs_pkg::pos_t           stk_rdata;

	bacs_pkg::blob_rec_t      tbl_mem [bacs_pkg::MAX_BLOBS];
	logic                     tbl_we;
	logic                     tbl_re;
	bacs_pkg::blob_rec_t      tbl_rdata;

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		if (bm_re) begin
			bm_rdata <= bm_mem[bm_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rdata <= stk_mem[stk_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[found_q[bacs_pkg::BIDX_W-1:0]] <= acc_q;
		end
		if (tbl_re) begin
			tbl_rdata <= tbl_mem[out_idx_q[bacs_pkg::BIDX_W-1:0]];
		end
	end

	// ------------------------------------------------------------------
	// Neighbour of the current fill pixel selected by nb_q.
	// ------------------------------------------------------------------
	logic             nb_ok;
	logic [POS_W-1:0] nb_addr;
	bacs_pkg::pos_t   nb_pos;

	always_comb begin
		nb_addr    = cur_addr_q;
		nb_pos.col = cur_col_q;
		nb_pos.row = cur_row_q;
		nb_ok      = 1'b0;
		case (nb_q)
			NB_RIGHT: begin
				nb_ok      = ({1'b0, cur_col_q} + (COL_W+1)'(1)) < w_eff;
				nb_addr    = cur_addr_q + POS_W'(1);
				nb_pos.col = cur_col_q + COL_W'(1);
			end
			NB_LEFT: begin
				nb_ok      = cur_col_q != '0;
				nb_addr    = cur_addr_q - POS_W'(1);
				nb_pos.col = cur_col_q - COL_W'(1);
			end
			NB_DOWN: begin
				nb_ok      = ({1'b0, cur_row_q} + (ROW_W+1)'(1)) < h_eff;
				nb_addr    = cur_addr_q + POS_W'(w_eff);
				nb_pos.row = cur_row_q + ROW_W'(1);
			end
			NB_UP: begin
				nb_ok      = cur_row_q != '0;
				nb_addr    = cur_addr_q - POS_W'(w_eff);
				nb_pos.row = cur_row_q - ROW_W'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
		// Positions past the loaded pixels read as background.
		nb_ok = nb_ok && (nb_addr < load_pos_q);
	end

	// ------------------------------------------------------------------
	// Memory port control.
	// ------------------------------------------------------------------
	logic pix_acc;
	logic out_free;
	logic scan_done;
	logic out_rd_q;

	assign pixels.ready = (state_q == ST_LOAD);
	assign pix_acc      = pixels.valid && pixels.ready;
	assign out_free     = !out_valid_q || blobs.ready;
	assign scan_done    = (scan_addr_q >= load_pos_q) ||
		(found_q == bacs_pkg::BCNT_W'(bacs_pkg::MAX_BLOBS));

	always_comb begin
		bm_we     = 1'b0;
		bm_wdata  = 1'b0;
		bm_waddr  = scan_addr_q[ADDR_W-1:0];
		bm_re     = 1'b0;
		bm_raddr  = scan_addr_q[ADDR_W-1:0];
		stk_we    = 1'b0;
		stk_waddr = sp_q[ADDR_W-1:0];
		stk_wdata = nb_pos;
		stk_re    = 1'b0;
		stk_raddr = ADDR_W'(sp_q - POS_W'(1));
		tbl_we    = 1'b0;
		tbl_re    = 1'b0;
		case (state_q)
			ST_LOAD: begin
				bm_we    = pix_acc && (load_pos_q < frame_size);
				bm_wdata = pixels.pixel_value != '0;
				bm_waddr = load_pos_q[ADDR_W-1:0];
			end
			ST_SCAN_RD: begin
				bm_re = !scan_done;
			end
			ST_SCAN_CHK: begin
				// A seed is cleared and pushed as the first stack entry.
				bm_we         = bm_rdata;
				stk_we        = bm_rdata;
				stk_wdata.col = scan_col_q;
				stk_wdata.row = scan_row_q;
			end
			ST_POP: begin
				stk_re = sp_q != '0;
				tbl_we = sp_q == '0;
			end
			ST_NB_RD: begin
				bm_re    = nb_ok;
				bm_raddr = nb_addr[ADDR_W-1:0];
			end
			ST_NB_CHK: begin
				bm_we    = bm_rdata;
				bm_waddr = nb_addr[ADDR_W-1:0];
				stk_we   = bm_rdata;
			end
			ST_OUT: begin
				// One table read per result: the next read waits until the
				// previous one has reached the output register.
				tbl_re = out_free && !out_rd_q && (found_q != '0) &&
					(out_idx_q < found_q);
			end
			default: begin
				bm_we = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_pos_q  <= '0;
			scan_addr_q <= '0;
			scan_col_q  <= '0;
			scan_row_q  <= '0;
			sp_q        <= '0;
			found_q     <= '0;
			out_idx_q   <= '0;
			nb_q        <= NB_RIGHT;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			cur_addr_q  <= '0;
			out_valid_q <= 1'b0;
			out_rd_q    <= 1'b0;
		end else begin
			if (out_valid_q && blobs.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (pix_acc) begin
						if (load_pos_q < frame_size) begin
							load_pos_q <= load_pos_q + POS_W'(1);
						end
						if (pixels.frame_end) begin
							state_q     <= ST_SCAN_RD;
							scan_addr_q <= '0;
							scan_col_q  <= '0;
							scan_row_q  <= '0;
							found_q     <= '0;
							out_idx_q   <= '0;
							out_rd_q    <= 1'b0;
						end
					end
				end
				ST_SCAN_RD: begin
					state_q <= scan_done ? ST_OUT : ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					scan_addr_q <= scan_addr_q + POS_W'(1);
					if (({1'b0, scan_col_q} + (COL_W+1)'(1)) == w_eff) begin
						scan_col_q <= '0;
						scan_row_q <= scan_row_q + ROW_W'(1);
					end else begin
						scan_col_q <= scan_col_q + COL_W'(1);
					end
					if (bm_rdata) begin
						sp_q    <= POS_W'(1);
						state_q <= ST_POP;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						found_q <= found_q + bacs_pkg::BCNT_W'(1);
						state_q <= ST_SCAN_RD;
					end else begin
						sp_q    <= sp_q - POS_W'(1);
						state_q <= ST_POP_W;
					end
				end
				ST_POP_W: begin
					cur_col_q  <= stk_rdata.col;
					cur_row_q  <= stk_rdata.row;
					cur_addr_q <= POS_W'(stk_rdata.row * w_eff) + POS_W'(stk_rdata.col);
					nb_q       <= NB_RIGHT;
					state_q    <= ST_NB_RD;
				end
				ST_NB_RD: begin
					if (nb_ok) begin
						state_q <= ST_NB_CHK;
					end else if (nb_q == NB_UP) begin
						state_q <= ST_POP;
					end else begin
						nb_q <= nb_q + 2'd1;
					end
				end
				ST_NB_CHK: begin
					if (bm_rdata) begin
						sp_q <= sp_q + POS_W'(1);
					end
					nb_q    <= nb_q + 2'd1;
					state_q <= (nb_q == NB_UP) ? ST_POP : ST_NB_RD;
				end
				ST_OUT: begin
					// Table read issued last cycle: present the result.
					out_rd_q <= tbl_re;
					if (out_rd_q) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= out_idx_q + bacs_pkg::BCNT_W'(1);
						if (out_idx_q == found_q - bacs_pkg::BCNT_W'(1)) begin
							state_q    <= ST_LOAD;
							load_pos_q <= '0;
						end
					end else if (out_free && (found_q == '0)) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_LOAD;
						load_pos_q  <= '0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Pixel accumulation for the current blob.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN_CHK) begin
			acc_q <= '0;
		end else if (state_q == ST_POP_W) begin
			acc_q.count <= acc_q.count + bacs_pkg::COUNT_W'(1);
			acc_q.xs    <= acc_q.xs + bacs_pkg::SUM_W'(stk_rdata.col);
			acc_q.ys    <= acc_q.ys + bacs_pkg::SUM_W'(stk_rdata.row);
		end
	end

	// Output register.
	logic [bacs_pkg::INDEX_W-1:0] o_index_q;
	bacs_pkg::blob_rec_t          o_rec_q;
	logic [bacs_pkg::TOTAL_W-1:0] o_total_q;
	logic                         o_last_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT) begin
			if (out_rd_q) begin
				o_index_q <= bacs_pkg::INDEX_W'(out_idx_q);
				o_rec_q   <= tbl_rdata;
				o_total_q <= bacs_pkg::TOTAL_W'(found_q);
				o_last_q  <= out_idx_q == found_q - bacs_pkg::BCNT_W'(1);
			end else if (out_free && (found_q == '0)) begin
				o_index_q <= '0;
				o_rec_q   <= '0;
				o_total_q <= '0;
				o_last_q  <= 1'b1;
			end
		end
	end

	assign blobs.valid       = out_valid_q;
	assign blobs.blob_index  = o_index_q;
	assign blobs.pixel_count = o_rec_q.count;
	assign blobs.x_sum       = o_rec_q.xs;
	assign blobs.y_sum       = o_rec_q.ys;
	assign blobs.blob_total  = o_total_q;
	assign blobs.last_blob   = o_last_q;

`ifndef NO_ASSERTIONS
	// The blob count never passes the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		found_q <= bacs_pkg::BCNT_W'(bacs_pkg::MAX_BLOBS))
		else $error("blob count over limit");

	// Every stacked pixel is a distinct loaded pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= load_pos_q)
		else $error("fill stack deeper than loaded pixels");

	// A push never lands beyond the stack memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (sp_q < POS_W'(bacs_pkg::PIX_CAP)))
		else $error("fill stack overflow");

	// A table read is followed by a valid result: the data passes the table
	// read register and then the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		tbl_re |-> ##2 out_valid_q)
		else $error("table read without result");
`endif

endmodule

### dv/bacs_tb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob area and centroid sums: testbench helper types
// Pixel pattern codes and the record of one frame row of the directed stimulus table.
// ----------------------------------------------------------------------------
package bacs_tb_pkg;

	// Pixel patterns of a stimulus frame.
	localparam int PAT_ZERO    = 0;
	localparam int PAT_ONES    = 1;
	localparam int PAT_CHECKER = 2;
	localparam int PAT_RANDOM  = 3;

	typedef struct {
		logic [8:0] width;
		logic [8:0] height;
		int         npix;     // pixels sent; the last one carries frame_end
		int         pattern;  // one of the PAT_ codes above
		logic       known;    // expected single result typed in below
		logic [bacs_pkg::COUNT_W-1:0] cnt;
		logic [bacs_pkg::SUM_W-1:0]   xs;
		logic [bacs_pkg::SUM_W-1:0]   ys;
		logic [bacs_pkg::TOTAL_W-1:0] tot;
	} frame_row_t;
endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blob area and centroid sums: testbench
// Drives frames of pixels, predicts per-blob sums with a flood fill of its
// own and checks every result, across several frame geometries.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [bacs_pkg::INDEX_W-1:0] idx;
		logic [bacs_pkg::COUNT_W-1:0] cnt;
		logic [bacs_pkg::SUM_W-1:0]   xs;
		logic [bacs_pkg::SUM_W-1:0]   ys;
		logic [bacs_pkg::TOTAL_W-1:0] tot;
		logic                         last;
	} blob_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	bacs_pixel_if pixels();
	bacs_blob_if blobs();

	blob_area_centroid_sums_top dut (
		.clk(clk), .arst_n(arst_n), .pixels(pixels.sink), .blobs(blobs.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: its own copy of registers and frame memory.
	logic [8:0] model_w, model_h;
	bit   model_pix[bacs_pkg::PIX_CAP];
	int   model_load;
	int   fill_buf[bacs_pkg::PIX_CAP];
	blob_res_t expected_blobs[$];

	int mismatches = 0;
	int idle_src = 0, idle_snk = 0;  // idle percentages
	int watchdog = 0;

	function automatic int clip_dim(logic [8:0] v, int mx);
		if (v == 0) return 1;
		if (v > mx) return mx;
		return int'(v);
	endfunction

	// Stores one pixel; on frame end, labels the frame and queues the results.
	task automatic predict_pixel(logic [7:0] pv, logic fe);
		int w, h, size, lim, found, sp, a, c, r;
		longint cnt, xs, ys;
		blob_res_t res[$];
		blob_res_t b;
		w = clip_dim(model_w, bacs_pkg::MAX_COLS);
		h = clip_dim(model_h, bacs_pkg::MAX_ROWS);
		size = w * h;
		if (model_load < size) begin
			model_pix[model_load] = (pv != 0);
			model_load++;
		end
		if (!fe) return;
		lim = model_load;
		found = 0;
		for (int s = 0; s < lim && found < bacs_pkg::MAX_BLOBS; s++) begin
			if (model_pix[s]) begin
				cnt = 0; xs = 0; ys = 0; sp = 0;
				model_pix[s] = 0;
				fill_buf[sp++] = s;
				while (sp > 0) begin
					a = fill_buf[--sp];
					c = a % w;
					r = a / w;
					cnt++; xs += c; ys += r;
					// Neighbour order right, left, down, up.
					if (c + 1 < w && a + 1 < lim && model_pix[a+1]) begin
						model_pix[a+1] = 0; fill_buf[sp++] = a + 1;
					end
					if (c > 0 && model_pix[a-1]) begin
						model_pix[a-1] = 0; fill_buf[sp++] = a - 1;
					end
					if (r + 1 < h && a + w < lim && model_pix[a+w]) begin
						model_pix[a+w] = 0; fill_buf[sp++] = a + w;
					end
					if (r > 0 && model_pix[a-w]) begin
						model_pix[a-w] = 0; fill_buf[sp++] = a - w;
					end
				end
				b.idx = bacs_pkg::INDEX_W'(found);
				b.cnt = bacs_pkg::COUNT_W'(cnt);
				b.xs  = bacs_pkg::SUM_W'(xs);
				b.ys  = bacs_pkg::SUM_W'(ys);
				res.push_back(b);
				found++;
			end
		end
		// Pixels left set past the scan stop are never read again: each frame
		// overwrites positions before the scan can reach them.
		for (int s = 0; s < lim; s++) model_pix[s] = 0;
		model_load = 0;
		if (found == 0) begin
			b = '{default: '0};
			b.last = 1'b1;
			expected_blobs.push_back(b);
		end else begin
			foreach (res[k]) begin
				res[k].tot = bacs_pkg::TOTAL_W'(found);
				res[k].last = (k == found - 1);
				expected_blobs.push_back(res[k]);
			end
		end
	endtask

	task automatic apb_write(int idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == int'(bacs_pkg::REG_WIDTH)) model_w = val[8:0];
		else model_h = val[8:0];
	endtask

	// Waits for the output side to drain, then lets the fill tail settle.
	task automatic wait_drained();
		while (expected_blobs.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic set_geometry(logic [8:0] w, logic [8:0] h);
		wait_drained();
		apb_write(int'(bacs_pkg::REG_WIDTH), 32'(w));
		apb_write(int'(bacs_pkg::REG_HEIGHT), 32'(h));
	endtask

	// Sends one pixel request and feeds the predictor when it is accepted.
	// valid stays high after the accept; the next request or the end of
	// the frame decides its next value.
	task automatic send_pixel(logic [7:0] pv, logic fe);
		while ($urandom_range(99) < idle_src) begin
			pixels.valid <= 1'b0;
			@(posedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.pixel_value <= pv;
		pixels.frame_end <= fe;
		@(posedge clk);
		while (!pixels.ready) @(posedge clk);
		predict_pixel(pv, fe);
	endtask

	function automatic logic [7:0] pick_pixel(int pattern, int i, int w, int dens);
		case (pattern)
			bacs_tb_pkg::PAT_ZERO: return 8'h00;
			bacs_tb_pkg::PAT_ONES: return 8'hFF;
			bacs_tb_pkg::PAT_CHECKER: return (((i % w) + (i / w)) % 2) ? 8'h80 : 8'h00;
			default: return ($urandom_range(99) < dens) ? 8'($urandom_range(1, 255)) : 8'h00;
		endcase
	endfunction

	task automatic send_frame(int npix, int pattern, int dens);
		int w;
		w = clip_dim(model_w, bacs_pkg::MAX_COLS);
		for (int i = 0; i < npix; i++)
			send_pixel(pick_pixel(pattern, i, w, dens), i == npix - 1);
		pixels.valid <= 1'b0;
	endtask

	// Result side: random stalls, compare against the oldest expectation.
	always @(posedge clk) begin
		blob_res_t e;
		if (arst_n && blobs.valid && blobs.ready) begin
			if (expected_blobs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected blob result idx=%0d", blobs.blob_index);
			end else begin
				e = expected_blobs.pop_front();
				if (blobs.blob_index !== e.idx || blobs.pixel_count !== e.cnt ||
						blobs.x_sum !== e.xs || blobs.y_sum !== e.ys ||
						blobs.blob_total !== e.tot || blobs.last_blob !== e.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("blob mismatch exp idx=%0d cnt=%0d xs=%0d ys=%0d tot=%0d last=%0d",
							e.idx, e.cnt, e.xs, e.ys, e.tot, e.last);
						$display("              act idx=%0d cnt=%0d xs=%0d ys=%0d tot=%0d last=%0d",
							blobs.blob_index, blobs.pixel_count, blobs.x_sum, blobs.y_sum,
							blobs.blob_total, blobs.last_blob);
					end
				end
			end
		end
		blobs.ready <= ($urandom_range(99) >= idle_snk);
	end

	// Watchdog on cycles with no accepted request on either channel.
	always @(posedge clk) begin
		if ((pixels.valid && pixels.ready) || (blobs.valid && blobs.ready) || !arst_n)
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog > 20000) begin
			$display("simulation failed");
			$finish;
		end
	end

	bacs_tb_pkg::frame_row_t directed[$];

	initial begin
		int w, h, np;
		pixels.valid = 1'b0;
		pixels.pixel_value = '0;
		pixels.frame_end = 1'b0;
		blobs.ready = 1'b0;
		model_w = 9'd256; model_h = 9'd256; model_load = 0;
		foreach (model_pix[i]) model_pix[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames. Known rows: empty frames, full frames, 1x1 frames, clipped frames.
		directed.push_back('{0, 0, 1, bacs_tb_pkg::PAT_ZERO, 1, 0, 0, 0, 0});  // zero is 1x1
		directed.push_back('{0, 0, 1, bacs_tb_pkg::PAT_ONES, 1, 1, 0, 0, 1});  // one pixel
		directed.push_back('{1, 1, 3, bacs_tb_pkg::PAT_ONES, 1, 1, 0, 0, 1});  // extra dropped
		directed.push_back('{3, 2, 6, bacs_tb_pkg::PAT_ONES, 1, 6, 6, 3, 1});  // full 3x2
		directed.push_back('{4, 4, 16, bacs_tb_pkg::PAT_ZERO, 1, 0, 0, 0, 0}); // empty 4x4
		directed.push_back('{4, 4, 16, bacs_tb_pkg::PAT_CHECKER, 0, 0, 0, 0, 0}); // 8 blobs
		directed.push_back('{8, 8, 64, bacs_tb_pkg::PAT_CHECKER, 0, 0, 0, 0, 0}); // limit 16
		directed.push_back('{5, 3, 7, bacs_tb_pkg::PAT_ONES, 0, 0, 0, 0, 0});  // short frame
		directed.push_back('{511, 1, 5, bacs_tb_pkg::PAT_ONES, 1, 5, 10, 0, 1}); // wide clip
		directed.push_back('{1, 300, 5, bacs_tb_pkg::PAT_ONES, 1, 5, 0, 10, 1}); // tall clip
		directed.push_back('{6, 5, 30, bacs_tb_pkg::PAT_RANDOM, 0, 0, 0, 0, 0});
		idle_src = 20; idle_snk = 71;
		foreach (directed[i]) begin
			set_geometry(directed[i].width, directed[i].height);
			if (directed[i].known) begin
				wait_drained();
				send_frame(directed[i].npix, directed[i].pattern, 50);
				// The predictor must agree with the typed-in value.
				if (expected_blobs.size() != 1 || expected_blobs[0].cnt !== directed[i].cnt ||
						expected_blobs[0].xs !== directed[i].xs ||
						expected_blobs[0].ys !== directed[i].ys ||
						expected_blobs[0].tot !== directed[i].tot) begin
					mismatches++;
					if (mismatches <= 10) $display("directed row %0d prediction differs", i);
				end
			end else
				send_frame(directed[i].npix, directed[i].pattern, 50);
		end

		// Random frames: small geometries, three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			idle_src = (ph == 0) ? 20 : (ph == 1) ? 71 : 0;
			idle_snk = (ph == 0) ? 71 : (ph == 1) ? 20 : 0;
			np = 0;
			while (np < 100) begin
				w = $urandom_range(1, 12);
				h = $urandom_range(1, 10);
				set_geometry(9'(w), 9'(h));
				np += w * h;
				case ($urandom_range(9))
					0: send_frame($urandom_range(1, w * h), bacs_tb_pkg::PAT_RANDOM, 40);
					1: send_frame(w * h + $urandom_range(1, 4), bacs_tb_pkg::PAT_RANDOM, 40);
					default: send_frame(w * h, bacs_tb_pkg::PAT_RANDOM, $urandom_range(10, 90));
				endcase
			end
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_blobs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
